/* rtl/fq8_pkg.sv */
// fq8_pkg: shared types, codes and helper functions for the fp32 quantizer
// no dependencies; used by fq8_sub, fq8_mul and the top level
`timescale 1ns / 1ps

package fq8_pkg;

   // register indexes on the csr port
   localparam logic [1:0] RegMode     = 2'd0;
   localparam logic [1:0] RegRangeMin = 2'd1;
   localparam logic [1:0] RegScale    = 2'd2;

   // output format codes
   localparam logic [1:0] ModeU8   = 2'd0;
   localparam logic [1:0] ModeS8   = 2'd1;
   localparam logic [1:0] ModeBf16 = 2'd2;

   localparam logic [31:0] ScaleReset = 32'h3F80_0000;

   // clamp limits, as magnitudes
   localparam logic [8:0] U8MaxMag  = 9'd255;
   localparam logic [8:0] S8MaxMag  = 9'd127;
   localparam logic [8:0] S8MinMag  = 9'd128;
   localparam logic [8:0] SatMag    = 9'd256;

   // bf16 keeps the upper half of the sample
   localparam int Bf16Shift = 16;

   typedef struct packed {
      logic [31:0] sample;
      logic        last_in;
   } req_type;

   typedef struct packed {
      logic [15:0] code;
      logic        last_out;
   } rsp_type;

   // per-beat sideband that rides along the pipeline
   typedef struct packed {
      logic        last;
      logic [1:0]  mode;
      logic [15:0] bf16;
   } side_type;

   // unpacked float: value = man * 2^(exp - 150) when not nan/inf
   typedef struct packed {
      logic              nan;
      logic              inf;
      logic              sign;
      logic signed [9:0] exp;
      logic [23:0]       man;
   } fnum_type;

   // rounded product: value = man * 2^(texp - 23), man normalized
   typedef struct packed {
      logic               nan;
      logic               inf;
      logic               zero;
      logic               sign;
      logic signed [10:0] texp;
      logic [23:0]        man;
   } prod_type;

   // leading zero count, 27 bits
   function automatic logic [4:0] lzc27(input logic [26:0] v);
      logic [4:0] n;
      logic       found;
      n     = 5'd27;
      found = 1'b0;
      for (int i = 26; i >= 0; i--) begin
         if (!found && v[i]) begin
            n     = 5'(26 - i);
            found = 1'b1;
         end
      end
      return n;
   endfunction

   // leading zero count, 24 bits
   function automatic logic [4:0] lzc24(input logic [23:0] v);
      logic [4:0] n;
      logic       found;
      n     = 5'd24;
      found = 1'b0;
      for (int i = 23; i >= 0; i--) begin
         if (!found && v[i]) begin
            n     = 5'(23 - i);
            found = 1'b1;
         end
      end
      return n;
   endfunction

endpackage

/* rtl/fq8_sub.sv */
// fq8_sub: three-stage fp32 subtract a - b, round to nearest even
// depends on fq8_pkg
`timescale 1ns / 1ps

module fq8_sub (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  fq8_pkg::side_type in_side,
   input  logic [31:0]       in_a,
   input  logic [31:0]       in_b,
   output logic              out_valid,
   output fq8_pkg::side_type out_side,
   output fq8_pkg::fnum_type out_res
);

   // stage a: unpack, order by magnitude, align smaller operand
   logic [31:0] b_neg, big, sml;
   logic        swap;
   logic [7:0]  big_e, sml_e, diff;
   logic [23:0] big_m, sml_m;
   logic [26:0] ext, mask, al_in;
   logic [4:0]  ash;
   logic        a_nan, a_inf, b_nan, b_inf, eff_sub_in, nan_in, inf_in;

   always_comb begin
      b_neg = {~in_b[31], in_b[30:0]};
      swap  = (b_neg[30:0] > in_a[30:0]);
      big   = swap ? b_neg : in_a;
      sml   = swap ? in_a : b_neg;
      big_e = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
      sml_e = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
      big_m = {big[30:23] != 8'd0, big[22:0]};
      sml_m = {sml[30:23] != 8'd0, sml[22:0]};
      diff  = big_e - sml_e;
      ext   = {sml_m, 3'b000};
      ash   = diff[4:0];
      mask  = (27'd1 << ash) - 27'd1;
      if (diff >= 8'd27) begin
         al_in = {26'd0, |sml_m};
      end else begin
         al_in = (ext >> ash) | {26'd0, |(ext & mask)};
      end
      a_nan      = (&in_a[30:23]) && (|in_a[22:0]);
      a_inf      = (&in_a[30:23]) && !(|in_a[22:0]);
      b_nan      = (&in_b[30:23]) && (|in_b[22:0]);
      b_inf      = (&in_b[30:23]) && !(|in_b[22:0]);
      eff_sub_in = big[31] ^ sml[31];
      nan_in     = a_nan | b_nan | (a_inf & b_inf & eff_sub_in);
      inf_in     = !nan_in & (a_inf | b_inf);
   end

   logic               a_valid_ff;
   fq8_pkg::side_type  a_side_ff;
   logic [23:0]        a_man_ff;
   logic [7:0]         a_exp_ff;
   logic               a_sign_ff, a_sub_ff, a_nan_ff, a_inf_ff;
   logic [26:0]        a_al_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      a_side_ff <= in_side;
      a_man_ff  <= big_m;
      a_exp_ff  <= big_e;
      a_sign_ff <= big[31];
      a_sub_ff  <= eff_sub_in;
      a_nan_ff  <= nan_in;
      a_inf_ff  <= inf_in;
      a_al_ff   <= al_in;
   end

   // stage b: add or subtract mantissas, count leading zeros
   logic [27:0] sum_in;
   logic [4:0]  lz_in;

   always_comb begin
      if (a_sub_ff) begin
         sum_in = {1'b0, a_man_ff, 3'b000} - {1'b0, a_al_ff};
      end else begin
         sum_in = {1'b0, a_man_ff, 3'b000} + {1'b0, a_al_ff};
      end
      lz_in = fq8_pkg::lzc27(sum_in[26:0]);
   end

   logic              b_valid_ff;
   fq8_pkg::side_type b_side_ff;
   logic [27:0]       b_sum_ff;
   logic [4:0]        b_lz_ff;
   logic [7:0]        b_exp_ff;
   logic              b_sign_ff, b_nan_ff, b_inf_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      b_side_ff <= a_side_ff;
      b_sum_ff  <= sum_in;
      b_lz_ff   <= lz_in;
      b_exp_ff  <= a_exp_ff;
      b_sign_ff <= a_sign_ff;
      b_nan_ff  <= a_nan_ff;
      b_inf_ff  <= a_inf_ff;
   end

   // stage c: normalize (stopping at the subnormal floor) and round
   logic [7:0]        lim, nsh;
   logic [26:0]       norm;
   logic [8:0]        ne;
   logic [24:0]       mr;
   logic              rup;
   fq8_pkg::fnum_type res_in;

   always_comb begin
      lim = b_exp_ff - 8'd1;
      nsh = ({3'd0, b_lz_ff} > lim) ? lim : {3'd0, b_lz_ff};
      if (b_sum_ff[27]) begin
         norm = {b_sum_ff[27:2], b_sum_ff[1] | b_sum_ff[0]};
         ne   = {1'b0, b_exp_ff} + 9'd1;
      end else begin
         norm = b_sum_ff[26:0] << nsh[4:0];
         ne   = {1'b0, b_exp_ff} - {1'b0, nsh};
      end
      rup = norm[2] & (norm[1] | norm[0] | norm[3]);
      mr  = {1'b0, norm[26:3]} + {24'd0, rup};
      if (mr[24]) begin
         mr = {1'b0, mr[24:1]};
         ne = ne + 9'd1;
      end
      res_in.nan  = b_nan_ff;
      res_in.inf  = b_inf_ff | (!b_nan_ff && ne >= 9'd255);
      res_in.sign = b_sign_ff;
      res_in.exp  = $signed({1'b0, ne});
      res_in.man  = mr[23:0];
   end

   logic              c_valid_ff;
   fq8_pkg::side_type c_side_ff;
   fq8_pkg::fnum_type c_res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else begin
         c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      c_side_ff <= b_side_ff;
      c_res_ff  <= res_in;
   end

   assign out_valid = c_valid_ff;
   assign out_side  = c_side_ff;
   assign out_res   = c_res_ff;

endmodule

/* rtl/fq8_mul.sv */
// fq8_mul: three-stage fp multiply of the difference by the scale, rounded to fp32
// depends on fq8_pkg
`timescale 1ns / 1ps

module fq8_mul (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  fq8_pkg::side_type in_side,
   input  fq8_pkg::fnum_type in_a,
   input  logic [31:0]       scale,
   output logic              out_valid,
   output fq8_pkg::side_type out_side,
   output fq8_pkg::prod_type out_prod
);

   // stage d: unpack scale, normalize both mantissas, resolve specials
   logic              s_nan, s_inf, s_zero, a_zero;
   logic [23:0]       s_man, an_in, sn_in;
   logic [4:0]        a_lz, s_lz;
   logic signed [9:0] s_exp, ae_in, se_in;
   logic              nan_in, inf_in, zero_in;

   always_comb begin
      s_nan  = (&scale[30:23]) && (|scale[22:0]);
      s_inf  = (&scale[30:23]) && !(|scale[22:0]);
      s_man  = {scale[30:23] != 8'd0, scale[22:0]};
      s_exp  = (scale[30:23] == 8'd0) ? 10'sd1 : $signed({2'b00, scale[30:23]});
      s_zero = !s_nan && !s_inf && (s_man == 24'd0);
      a_zero = !in_a.nan && !in_a.inf && (in_a.man == 24'd0);
      a_lz   = fq8_pkg::lzc24(in_a.man);
      s_lz   = fq8_pkg::lzc24(s_man);
      an_in  = in_a.man << a_lz;
      sn_in  = s_man << s_lz;
      ae_in  = in_a.exp - $signed({5'd0, a_lz});
      se_in  = s_exp - $signed({5'd0, s_lz});
      nan_in  = in_a.nan | s_nan | (in_a.inf & s_zero) | (s_inf & a_zero);
      inf_in  = !nan_in & (in_a.inf | s_inf);
      zero_in = !nan_in & !inf_in & (a_zero | s_zero);
   end

   logic              d_valid_ff;
   fq8_pkg::side_type d_side_ff;
   logic [23:0]       d_am_ff, d_sm_ff;
   logic signed [9:0] d_ae_ff, d_se_ff;
   logic              d_nan_ff, d_inf_ff, d_zero_ff, d_sign_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
      end else begin
         d_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      d_side_ff <= in_side;
      d_am_ff   <= an_in;
      d_sm_ff   <= sn_in;
      d_ae_ff   <= ae_in;
      d_se_ff   <= se_in;
      d_nan_ff  <= nan_in;
      d_inf_ff  <= inf_in;
      d_zero_ff <= zero_in;
      d_sign_ff <= in_a.sign ^ scale[31];
   end

   // stage e: mantissa product and exponent sum
   logic [47:0]        p_in;
   logic signed [10:0] esum_in;

   assign p_in    = {24'd0, d_am_ff} * {24'd0, d_sm_ff};
   assign esum_in = 11'(d_ae_ff) + 11'(d_se_ff);

   logic               e_valid_ff;
   fq8_pkg::side_type  e_side_ff;
   logic [47:0]        e_p_ff;
   logic signed [10:0] e_esum_ff;
   logic               e_nan_ff, e_inf_ff, e_zero_ff, e_sign_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
      end else begin
         e_valid_ff <= d_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      e_side_ff <= d_side_ff;
      e_p_ff    <= p_in;
      e_esum_ff <= esum_in;
      e_nan_ff  <= d_nan_ff;
      e_inf_ff  <= d_inf_ff;
      e_zero_ff <= d_zero_ff;
      e_sign_ff <= d_sign_ff;
   end

   // stage f: one-bit normalize and round the product to 24 bits
   logic [23:0]        pm;
   logic               pg, pst, pup;
   logic [24:0]        pr;
   logic signed [10:0] pt;
   fq8_pkg::prod_type  prod_in;

   always_comb begin
      if (e_p_ff[47]) begin
         pm  = e_p_ff[47:24];
         pg  = e_p_ff[23];
         pst = |e_p_ff[22:0];
         pt  = e_esum_ff - 11'sd253;
      end else begin
         pm  = e_p_ff[46:23];
         pg  = e_p_ff[22];
         pst = |e_p_ff[21:0];
         pt  = e_esum_ff - 11'sd254;
      end
      pup = pg & (pst | pm[0]);
      pr  = {1'b0, pm} + {24'd0, pup};
      if (pr[24]) begin
         pr = {1'b0, pr[24:1]};
         pt = pt + 11'sd1;
      end
      prod_in.nan  = e_nan_ff;
      prod_in.inf  = e_inf_ff;
      prod_in.zero = e_zero_ff;
      prod_in.sign = e_sign_ff;
      prod_in.texp = pt;
      prod_in.man  = pr[23:0];
   end

   logic              f_valid_ff;
   fq8_pkg::side_type f_side_ff;
   fq8_pkg::prod_type f_prod_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
      end else begin
         f_valid_ff <= e_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      f_side_ff <= e_side_ff;
      f_prod_ff <= prod_in;
   end

   assign out_valid = f_valid_ff;
   assign out_side  = f_side_ff;
   assign out_prod  = f_prod_ff;

endmodule

/* rtl/fp32_to_int8_bf16_quantizer_top.sv */
// fp32_to_int8_bf16_quantizer_top: csr bank, sub/mul pipeline, integer round and clamp
// depends on fq8_pkg, fq8_sub, fq8_mul
`timescale 1ns / 1ps

// Quantizes one fp32 sample per beat into a u8, s8 or bf16 code.
// Input: a beat is taken at a rising edge with start high and busy low;
//   req_data carries the sample and its last flag. busy is low except in reset,
//   so a new sample may be offered on every cycle.
// Output: rsp_valid marks rsp_data for exactly one cycle; it cannot be held off.
// Pipeline: an accepted beat passes through registered stages on its way to
//   rsp_valid (subtract: 3 stages, multiply: 3 stages, round/clamp: 1).
// Throughput: one beat per cycle, set by the fully pipelined fp multiplier and
//   adder; beats leave in the order they entered.
// Csr: csr_we with csr_index 0 (mode), 1 (range_min), 2 (scale) writes csr_wdata
//   at the edge; other indexes are ignored. Change registers only while no beat
//   is in flight; mode is sampled as the beat enters.
// Reset: synchronous, clears the pipeline valid bits and loads mode 0,
//   range_min 0.0 and scale 1.0.

module fp32_to_int8_bf16_quantizer_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  fq8_pkg::req_type req_data,
   output logic             rsp_valid,
   output fq8_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic [1:0]       csr_index,
   input  logic [31:0]      csr_wdata
);

   // configuration registers
   logic [1:0]  mode_ff;
   logic [31:0] range_min_ff, scale_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= fq8_pkg::ModeU8;
         range_min_ff <= 32'd0;
         scale_ff     <= fq8_pkg::ScaleReset;
      end else if (csr_we) begin
         unique case (csr_index)
            fq8_pkg::RegMode:     mode_ff      <= csr_wdata[1:0];
            fq8_pkg::RegRangeMin: range_min_ff <= csr_wdata;
            fq8_pkg::RegScale:    scale_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   // beat entry; every mode but u8 (signed and bf16) subtracts zero
   logic              accept;
   fq8_pkg::side_type in_side;
   logic [31:0]       sub_b;

   assign busy    = reset;
   assign accept  = start && !busy;
   assign in_side = '{last: req_data.last_in, mode: mode_ff,
                      bf16: req_data.sample[31:fq8_pkg::Bf16Shift]};
   assign sub_b   = (mode_ff == fq8_pkg::ModeU8) ? range_min_ff : 32'd0;

   logic              c_valid;
   fq8_pkg::side_type c_side;
   fq8_pkg::fnum_type c_res;

   fq8_sub u_sub (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_side   (in_side),
      .in_a      (req_data.sample),
      .in_b      (sub_b),
      .out_valid (c_valid),
      .out_side  (c_side),
      .out_res   (c_res)
   );

   logic              f_valid;
   fq8_pkg::side_type f_side;
   fq8_pkg::prod_type f_prod;

   fq8_mul u_mul (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (c_valid),
      .in_side   (c_side),
      .in_a      (c_res),
      .scale     (scale_ff),
      .out_valid (f_valid),
      .out_side  (f_side),
      .out_prod  (f_prod)
   );

   // stage g: round to integer (ties to even), clamp, pick the format
   logic [4:0]       rsh, rsh_m1;
   logic [23:0]      ipart;
   logic             half, sticky;
   logic [8:0]       mag, lim;
   logic [7:0]       byte_val;
   fq8_pkg::rsp_type rsp_in;

   always_comb begin
      rsh    = 5'(11'sd23 - f_prod.texp);
      rsh_m1 = rsh - 5'd1;
      ipart  = f_prod.man >> rsh;
      half   = f_prod.man[rsh_m1];
      sticky = |(f_prod.man & ((24'd1 << rsh_m1) - 24'd1));
      if (f_prod.nan || f_prod.zero) begin
         mag = 9'd0;
      end else if (f_prod.inf || f_prod.texp >= 11'sd8) begin
         mag = fq8_pkg::SatMag;
      end else if (f_prod.texp <= -11'sd2) begin
         mag = 9'd0;
      end else begin
         mag = ipart[8:0] + {8'd0, half & (sticky | ipart[0])};
      end
      if (f_side.mode == fq8_pkg::ModeU8) begin
         lim = f_prod.sign ? 9'd0 : fq8_pkg::U8MaxMag;
      end else begin
         lim = f_prod.sign ? fq8_pkg::S8MinMag : fq8_pkg::S8MaxMag;
      end
      if (mag > lim) begin
         mag = lim;
      end
      byte_val = f_prod.sign ? 8'(9'd0 - mag) : mag[7:0];
      case (f_side.mode) inside
         fq8_pkg::ModeU8, fq8_pkg::ModeS8: rsp_in.code = {8'd0, byte_val};
         fq8_pkg::ModeBf16:                rsp_in.code = f_side.bf16;
         default:                          rsp_in.code = 16'd0;
      endcase
      rsp_in.last_out = f_side.last;
   end

   logic             rsp_valid_ff;
   fq8_pkg::rsp_type rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= f_valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // every result beat traces back to an accepted input beat
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(accept, 7))
      else $error("result beat without a matching input beat");

   // an upper code byte appears only in bf16 mode
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.code[15:8] != 8'd0) |-> $past(f_side.mode) == fq8_pkg::ModeBf16)
      else $error("upper code byte set outside bf16 mode");

   // a nan product always yields code zero in the byte modes
   assert property (@(posedge clock) disable iff (reset)
      $past(f_valid && f_prod.nan && f_side.mode != fq8_pkg::ModeBf16)
      |-> rsp_ff.code == 16'd0)
      else $error("nan product gave a nonzero code");

endmodule
